@@ hw/rtl/stream_dedup_compact_top_defines.svh @@
// Assertion macros for the stream dedup block.
// Used by stream_dedup_compact_top.sv; depends on nothing else.
`ifndef STREAM_DEDUP_COMPACT_TOP_DEFINES_SVH
`define STREAM_DEDUP_COMPACT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdc same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdc next-cycle check failed");

`endif

@@ hw/rtl/sdc_pkg.sv @@
// Shared types and constants for the stream dedup block.
// No dependencies.
package sdc_pkg;

  // data word width of the stream
  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // broadcast from the sequencer to every cell in the chain
  typedef struct packed {
    logic  shift;  // push word into cell 0, every cell takes its neighbor
    word_t word;   // compare probe, also the value pushed in
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sdc_cell.sv @@
// One storage cell of the kept-value chain: holds a word, compares it.
// Depends on sdc_pkg.
module sdc_cell (
  input  logic                clk,
  input  sdc_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  sdc_pkg::word_t      prev_value,
  output sdc_pkg::word_t      value,
  output logic                hit
);

  sdc_pkg::word_t value_r;

  // shift from the neighbor when a new word is kept
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value_r <= prev_value;
    end
  end

  assign value = value_r;
  assign hit   = occupied && (value_r == ctrl.word);

endmodule

@@ hw/rtl/sdc_chain.sv @@
// Row of sdc_cell instances; newest word enters cell 0, older ones move up.
// Depends on sdc_pkg and sdc_cell.
module sdc_chain #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5
) (
  input  logic                clk,
  input  sdc_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    kept_count,
  output logic                any_hit
);

  sdc_pkg::word_t       values [DEPTH];
  logic [DEPTH-1:0]     hits;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      sdc_pkg::word_t prev;
      logic           occ;

      // cell i holds a kept word when i is below the count
      assign occ = (CNT_W'(i) < kept_count);

      if (i == 0) begin : g_head
        assign prev = ctrl.word;
      end else begin : g_body
        assign prev = values[i-1];
      end

      sdc_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ),
        .prev_value (prev),
        .value      (values[i]),
        .hit        (hits[i])
      );
    end
  endgenerate

  assign any_hit = |hits;

endmodule

@@ hw/rtl/stream_dedup_compact_top.sv @@
// Top level of the stream dedup block: sequencer, counters, output register.
// Depends on sdc_pkg, sdc_chain and stream_dedup_compact_top_defines.svh.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid, in_stall, in_value, in_last          | in
//  out     | out_valid, out_stall, out_result_value,        | out
//          | out_final_res, out_overflow                    |
//
// Each word is accepted, compared against the cell chain and, when kept,
// emitted; the last word also emits its zero beats (each pad, or the lone
// marker); the sequencer handles one word at a time, stalling the input.
// Output stalls hold the sequencer in its emit states.
// rst_n is synchronous; it clears the item and kept counters, sequencer and output valid.
`include "stream_dedup_compact_top_defines.svh"

module stream_dedup_compact_top #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_final_res,
  output logic               out_overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_NEWV,
    S_PADS
  } state_t;

  state_t               state_r;
  sdc_pkg::word_t       item_value_r;
  logic                 item_last_r;
  logic [CNT_W-1:0]     item_count_r;
  logic [CNT_W-1:0]     kept_count_r;
  logic                 seq_ovf_r;
  logic [CNT_W-1:0]     pad_cnt_r;
  logic                 emit_ovf_r;
  logic                 out_valid_r;
  sdc_pkg::word_t       out_value_r;
  logic                 out_final_r;
  logic                 out_ovf_r;

  sdc_pkg::cell_ctrl_t  ctrl;
  logic                 any_hit;
  logic                 in_fire;
  logic                 out_free;
  logic                 emit;
  logic                 room;
  logic                 is_new;
  logic [CNT_W-1:0]     item_count_nxt;
  logic [CNT_W-1:0]     kept_count_nxt;
  logic                 seq_ovf_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // a new beat loads the output register this cycle
  assign emit     = out_free && ((state_r == S_NEWV) || (state_r == S_PADS));

  // membership test and counter update for the word under evaluation
  assign room           = (item_count_r < CNT_W'(MAX_ITEMS));
  assign is_new         = room && (item_value_r != '0) && !any_hit;
  assign item_count_nxt = room ? item_count_r + CNT_W'(1) : item_count_r;
  assign kept_count_nxt = is_new ? kept_count_r + CNT_W'(1) : kept_count_r;
  assign seq_ovf_nxt    = seq_ovf_r || !room;

  assign ctrl.shift = (state_r == S_EVAL) && is_new;
  assign ctrl.word  = item_value_r;

  sdc_chain #(
    .DEPTH (MAX_ITEMS),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .kept_count (kept_count_r),
    .any_hit    (any_hit)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      item_count_r <= '0;
      kept_count_r <= '0;
      seq_ovf_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (!out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            item_value_r <= in_value;
            item_last_r  <= in_last;
            state_r      <= S_EVAL;
          end
        end
        S_EVAL: begin
          pad_cnt_r  <= item_count_nxt - kept_count_nxt;
          emit_ovf_r <= seq_ovf_nxt;
          if (item_last_r) begin
            // sequence ends: start the next one from empty
            item_count_r <= '0;
            kept_count_r <= '0;
            seq_ovf_r    <= 1'b0;
          end else begin
            item_count_r <= item_count_nxt;
            kept_count_r <= kept_count_nxt;
            seq_ovf_r    <= seq_ovf_nxt;
          end
          priority if (is_new) begin
            state_r <= S_NEWV;
          end else if (item_last_r) begin
            state_r <= S_PADS;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_NEWV: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= item_value_r;
            out_final_r <= item_last_r && (pad_cnt_r == '0);
            out_ovf_r   <= item_last_r && (pad_cnt_r == '0) && emit_ovf_r;
            state_r     <= (item_last_r && (pad_cnt_r != '0)) ? S_PADS : S_IDLE;
          end
        end
        S_PADS: begin
          // zero pads; with none deferred a single marked zero goes out
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= '0;
            out_final_r <= (pad_cnt_r <= CNT_W'(1));
            out_ovf_r   <= (pad_cnt_r <= CNT_W'(1)) && emit_ovf_r;
            if (pad_cnt_r <= CNT_W'(1)) begin
              state_r <= S_IDLE;
            end else begin
              pad_cnt_r <= pad_cnt_r - CNT_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_final_res    = out_final_r;
  assign out_overflow     = out_ovf_r;

  // checks
  `SDC_ASSERT_IMP(a_kept_le_items, clk, rst_n, 1'b1, kept_count_r <= item_count_r)
  `SDC_ASSERT_IMP(a_items_le_max, clk, rst_n, 1'b1, item_count_r <= CNT_W'(MAX_ITEMS))
  `SDC_ASSERT_IMP(a_ovf_on_final, clk, rst_n, out_valid_r && out_ovf_r, out_final_r)
  `SDC_ASSERT_NXT(a_accept_evals, clk, rst_n, in_fire, state_r == S_EVAL)

endmodule

@@ tb/sdc_tb_pkg.sv @@
// Scoreboard for the stream dedup block: predicts the result beats of each
// accepted input beat and checks the beats that come out. Depends on sdc_pkg.
package sdc_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import sdc_pkg::word_t;

  // one predicted result beat
  typedef struct packed {
    word_t value;
    logic  fin;
    logic  ovf;
  } dedup_beat_t;

  class dedup_scoreboard;
    int unsigned max_items;
    word_t       kept_words[$];
    int unsigned words_in_seq;
    bit          dropped_in_seq;
    dedup_beat_t due_beats[$];
    int unsigned errors;
    int unsigned words_seen;
    int unsigned results_seen;
    int unsigned seqs_seen;
    int unsigned ovf_seqs_seen;

    function new(int unsigned max_items);
      this.max_items = max_items;
    endfunction

    function int unsigned pending();
      return due_beats.size();
    endfunction

    // Work out the result beats caused by one accepted input beat
    function void note_word(word_t v, logic last);
      int unsigned first;
      int unsigned pads;
      bit          seen;
      first = due_beats.size();
      words_seen++;
      if (words_in_seq < max_items) begin
        words_in_seq++;
        seen = 1'b0;
        foreach (kept_words[i])
          if (kept_words[i] == v) seen = 1'b1;
        if (v != '0 && !seen && kept_words.size() < max_items) begin
          kept_words.push_back(v);
          due_beats.push_back('{v, 1'b0, 1'b0});
        end
      end else begin
        dropped_in_seq = 1'b1;
      end
      if (last) begin
        // zero pads for duplicates and zeros, then mark the closing beat
        pads = words_in_seq - kept_words.size();
        repeat (pads) due_beats.push_back('{word_t'(0), 1'b0, 1'b0});
        if (due_beats.size() == first) begin
          // last word dropped for capacity, nothing deferred: lone marker
          due_beats.push_back('{word_t'(0), 1'b1, dropped_in_seq});
        end else begin
          due_beats[due_beats.size()-1].fin = 1'b1;
          due_beats[due_beats.size()-1].ovf = dropped_in_seq;
        end
        seqs_seen++;
        if (dropped_in_seq) ovf_seqs_seen++;
        kept_words.delete();
        words_in_seq   = 0;
        dropped_in_seq = 1'b0;
      end
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_result(word_t value, logic fin, logic ovf);
      dedup_beat_t exp_beat;
      results_seen++;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected result beat: value=%0d final=%0b overflow=%0b",
                 $time, $signed(value), fin, ovf);
        errors++;
        return;
      end
      exp_beat = due_beats.pop_front();
      if (value !== exp_beat.value) begin
        $display("%0t: result_value mismatch: expected %0d, actual %0d",
                 $time, $signed(exp_beat.value), $signed(value));
        errors++;
      end
      if (fin !== exp_beat.fin) begin
        $display("%0t: final_res mismatch: expected %0b, actual %0b",
                 $time, exp_beat.fin, fin);
        errors++;
      end
      if (ovf !== exp_beat.ovf) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b",
                 $time, exp_beat.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_stream_dedup_compact_top.sv @@
// Testbench top for stream_dedup_compact_top: directed and random sequences,
// bursty input, patterned output stalls. Depends on sdc_pkg and sdc_tb_pkg.
module tb_stream_dedup_compact_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdc_pkg::word_t;
  import sdc_tb_pkg::*;

  localparam int unsigned MAX_ITEMS   = 16;
  localparam int unsigned TOTAL_WORDS = 470;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 40;

  localparam word_t EDGE_WORDS [5] = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                       32'h0000_0000, 32'hffff_ffff};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  word_t       in_value;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic signed [31:0] out_result_value;
  logic        out_final_res;
  logic        out_overflow;

  dedup_scoreboard sb;
  int unsigned     idle_cycles;
  int unsigned     burst_left;
  bit              hold_req;
  bit              hold_done;

  stream_dedup_compact_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one beat, after a random gap when a burst runs out
  task automatic send_word(input word_t v, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (hold_req && !hold_done) gap = 0;  // keep pushing while output is held
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stop offering and wait for every predicted beat to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Stimulus
  initial begin
    word_t       pool [6];
    word_t       w;
    int unsigned words_sent;
    int unsigned seq_len;
    int unsigned r;
    bit          pool_mode;
    bit          drained;
    sb = new(MAX_ITEMS);
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    in_last  <= 1'b0;
    burst_left = 0;
    hold_req   = 1'b0;
    drained    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, a duplicate and a zero in one sequence
    foreach (EDGE_WORDS[i]) send_word(EDGE_WORDS[i], i == 4);
    // single-word sequences: a lone zero pads, a lone value passes
    send_word(32'h0, 1'b1);
    send_word(32'h5, 1'b1);
    // full capacity, then the last word dropped with no pads deferred
    for (int i = 0; i < MAX_ITEMS; i++) send_word(word_t'(1) << (2 * i), 1'b0);
    send_word(32'h1234, 1'b1);
    words_sent = 24;

    // random sequences, mostly short, some past capacity
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= 140) hold_req = 1'b1;
      if (!drained && words_sent >= 300) begin
        wait_drained();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      seq_len = (r < 65) ? $urandom_range(1, 8) :
                (r < 88) ? $urandom_range(9, MAX_ITEMS) :
                           $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 5);
      // small value pool per sequence gives plenty of duplicates
      pool_mode = ($urandom_range(0, 2) != 0);
      foreach (pool[i])
        pool[i] = ($urandom_range(0, 3) == 0) ? EDGE_WORDS[$urandom_range(0, 4)] : $urandom;
      for (int k = 0; k < seq_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15)         w = '0;
        else if (pool_mode) w = pool[$urandom_range(0, 5)];
        else                w = $urandom;
        send_word(w, k == seq_len - 1);
      end
      words_sent += seq_len;
    end

    // wind down
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d words in %0d sequences (%0d with dropped words), %0d result beats.",
             sb.words_seen, sb.seqs_seen, sb.ovf_seqs_seen, sb.results_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_stream_dedup_compact_top: PASS");
    end else begin
      $display("tb_stream_dedup_compact_top: FAIL");
    end
    $finish;
  end

  // Output stalls: random-density stretches, plus one long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned stall_pct;
    out_stall <= 1'b0;
    hold_left = 0;
    run_left  = 0;
    stall_pct = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Monitor both channels; count cycles with no beat moving
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_word(in_value, in_last);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_result_value, out_final_res, out_overflow);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("tb_stream_dedup_compact_top: FAIL");
    $finish;
  end

endmodule
